// ===== hw/rtl/scc_pkg.sv =====
package scc_pkg;

  localparam int unsigned MaxDim     = 256;
  localparam int unsigned CoordW     = 14;
  localparam int unsigned CellW      = 8;
  localparam int unsigned AddrW      = 2 * CellW;
  localparam int unsigned DimW       = 9;
  localparam int unsigned FracBits   = 6;
  localparam int unsigned SampleSpc  = 3;
  localparam int unsigned Spacing    = SampleSpc << FracBits;
  localparam int unsigned RootW      = 15;
  // radicand padded to an even width so bit pairs line up with the root steps
  localparam int unsigned SqW        = 2 * RootW;
  localparam int unsigned NW         = 8;
  localparam int unsigned NumW       = CoordW + NW;
  localparam int unsigned DenW       = NW + FracBits;
  localparam int unsigned QW         = NumW - FracBits;
  localparam int unsigned QDepth     = 2;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] CfgWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeight = 2'd1;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqCheck = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [CellW-1:0]  cell_col;
    logic [CellW-1:0]  cell_row;
    logic              cell_blocked;
    logic [CoordW-1:0] seg_start_x;
    logic [CoordW-1:0] seg_start_y;
    logic [CoordW-1:0] seg_end_x;
    logic [CoordW-1:0] seg_end_y;
  } req_t;

  typedef struct packed {
    logic path_free;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [DimW-1:0]    data;
  } cfg_t;

  // queued operation from front to back
  typedef struct packed {
    logic              is_check;
    logic [AddrW-1:0]  addr;
    logic              blocked;
    logic [CoordW-1:0] sx;
    logic [CoordW-1:0] sy;
    logic [CoordW-1:0] ex;
    logic [CoordW-1:0] ey;
    logic [NW-1:0]     n;
  } op_t;

  typedef enum logic [1:0] {
    FrIdle,
    FrSquare,
    FrRoot,
    FrPush
  } front_state_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkClear,
    BkDiv,
    BkRead,
    BkTest,
    BkResp
  } back_state_e;

endpackage

// ===== hw/rtl/scc_if.sv =====
interface scc_req_if;
  import scc_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scc_rsp_if;
  import scc_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scc_cfg_if;
  import scc_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/scc_front.sv =====
module scc_front import scc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  scc_req_if.sink    req,
  output logic       push_o,
  output op_t        op_o,
  input  logic       full_i
);

  front_state_e state_q, state_d;
  req_t         req_q;
  logic [SqW-1:0]   sq_q, sq_d;
  logic [SqW-1:0]   rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [3:0]       step_q, step_d;
  logic [CoordW-1:0] dx, dy;
  logic [SqW-1:0]    trial;
  logic [SqW-1:0]    cur;
  logic [RootW-1:0]  nq;

  assign dx = (req_q.seg_start_x > req_q.seg_end_x) ? req_q.seg_start_x - req_q.seg_end_x
                                                    : req_q.seg_end_x - req_q.seg_start_x;
  assign dy = (req_q.seg_start_y > req_q.seg_end_y) ? req_q.seg_start_y - req_q.seg_end_y
                                                    : req_q.seg_end_y - req_q.seg_start_y;

  // restoring square root, one result bit per cycle
  assign cur   = {rem_q[SqW-3:0], sq_q[SqW-1 -: 2]};
  assign trial = SqW'({root_q, 2'b01});

  // n = root / 192 + 1, root below 2^15 so n below 2^8
  assign nq = RootW'((32'(root_q) * 32'd43691) >> 23);

  always_comb begin
    state_d = state_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    root_d  = root_q;
    step_d  = step_q;
    push_o  = 1'b0;
    req.ready = (state_q == FrIdle);
    op_o.is_check = req_q.req_type;
    op_o.addr     = {req_q.cell_row, req_q.cell_col};
    op_o.blocked  = req_q.cell_blocked;
    op_o.sx = req_q.seg_start_x;
    op_o.sy = req_q.seg_start_y;
    op_o.ex = req_q.seg_end_x;
    op_o.ey = req_q.seg_end_y;
    op_o.n  = NW'(nq + RootW'(1));
    unique case (state_q)
      FrIdle: begin
        if (req.valid) begin
          state_d = (req.data.req_type == ReqCheck) ? FrSquare : FrPush;
        end
      end
      FrSquare: begin
        sq_d    = SqW'(32'(dx) * 32'(dx)) + SqW'(32'(dy) * 32'(dy));
        rem_d   = '0;
        root_d  = '0;
        step_d  = '0;
        state_d = FrRoot;
      end
      FrRoot: begin
        if (cur >= trial) begin
          rem_d  = cur - trial;
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_d  = cur;
          root_d = {root_q[RootW-2:0], 1'b0};
        end
        sq_d   = {sq_q[SqW-3:0], 2'b00};
        step_d = step_q + 4'd1;
        if (step_q == 4'(RootW - 1)) state_d = FrPush;
      end
      FrPush: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FrIdle;
        end
      end
      default: state_d = FrIdle;
    endcase
  end

  // state and operands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) req_q <= req.data;
    sq_q   <= sq_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    step_q <= step_d;
  end

endmodule

// ===== hw/rtl/scc_queue.sv =====
module scc_queue import scc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output op_t  op_o
);

  op_t        mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'(QDepth));
  assign empty_o = (cnt_q == 2'd0);
  assign op_o    = mem_q[rp_q];

  // two-entry fifo
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= op_i;
  end

endmodule

// ===== hw/rtl/scc_back.sv =====
module scc_back import scc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  op_t             op_i,
  output logic            pop_o,
  input  logic [DimW-1:0] wlim_i,
  input  logic [DimW-1:0] hlim_i,
  scc_rsp_if.source       rsp
);

  back_state_e  state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [NW-1:0]    i_q, i_d;
  logic [NumW-1:0]  numx_q, numx_d, numy_q, numy_d;
  logic [NumW-1:0]  remx_q, remx_d, remy_q, remy_d;
  logic [QW-1:0]    qx_q, qx_d, qy_q, qy_d;
  logic [4:0]       bit_q, bit_d;
  logic             free_q, free_d;
  logic             rv_q, rv_d;
  logic             mem_we;
  logic [AddrW-1:0] mem_wa, mem_ra;
  logic             mem_wd, mem_rd_q;
  logic             mem [2**AddrW];
  logic [DenW-1:0]  den;
  logic [NumW:0]    tx, ty;
  logic [QW-1:0]    qx_n, qy_n;
  logic [NumW-1:0]  rx_n, ry_n;

  assign den = {op_i.n, FracBits'(0)};

  // one quotient bit for both coordinates
  always_comb begin
    tx = {remx_q, numx_q[NumW-1]};
    ty = {remy_q, numy_q[NumW-1]};
    if (tx >= (NumW+1)'(den)) begin
      rx_n = NumW'(tx - (NumW+1)'(den));
      qx_n = {qx_q[QW-2:0], 1'b1};
    end else begin
      rx_n = NumW'(tx);
      qx_n = {qx_q[QW-2:0], 1'b0};
    end
    if (ty >= (NumW+1)'(den)) begin
      ry_n = NumW'(ty - (NumW+1)'(den));
      qy_n = {qy_q[QW-2:0], 1'b1};
    end else begin
      ry_n = NumW'(ty);
      qy_n = {qy_q[QW-2:0], 1'b0};
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q; i_d = i_q;
    numx_d = numx_q; numy_d = numy_q;
    remx_d = remx_q; remy_d = remy_q;
    qx_d = qx_q; qy_d = qy_q;
    bit_d = bit_q; free_d = free_q; rv_d = rv_q;
    pop_o  = 1'b0;
    mem_we = 1'b0;
    mem_wa = op_i.addr;
    mem_wd = op_i.blocked;
    mem_ra = {qy_q[CellW-1:0], qx_q[CellW-1:0]};
    if (rsp.valid && rsp.ready) rv_d = 1'b0;
    unique case (state_q)
      BkClear: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = 1'b0;
        clr_d  = clr_q + AddrW'(1);
        if (&clr_q) state_d = BkIdle;
      end
      BkIdle: begin
        if (!empty_i) begin
          if (!op_i.is_check) begin
            mem_we = 1'b1;
            pop_o  = 1'b1;
          end else begin
            i_d = '0; free_d = 1'b1;
            numx_d = NumW'(32'(op_i.sx) * 32'(op_i.n));
            numy_d = NumW'(32'(op_i.sy) * 32'(op_i.n));
            remx_d = '0; remy_d = '0; bit_d = '0;
            state_d = BkDiv;
          end
        end
      end
      BkDiv: begin
        remx_d = rx_n; remy_d = ry_n; qx_d = qx_n; qy_d = qy_n;
        numx_d = {numx_q[NumW-2:0], 1'b0};
        numy_d = {numy_q[NumW-2:0], 1'b0};
        bit_d  = bit_q + 5'd1;
        if (bit_q == 5'(NumW - 1)) state_d = BkRead;
      end
      BkRead: begin
        state_d = BkTest;
      end
      BkTest: begin
        if (qx_q >= QW'(wlim_i) || qy_q >= QW'(hlim_i) || mem_rd_q) begin
          free_d  = 1'b0;
          state_d = BkResp;
        end else if (i_q == op_i.n) begin
          state_d = BkResp;
        end else begin
          i_d = i_q + NW'(1);
          numx_d = NumW'(32'(op_i.sx) * 32'(op_i.n - i_q - NW'(1))
                       + 32'(op_i.ex) * 32'(i_q + NW'(1)));
          numy_d = NumW'(32'(op_i.sy) * 32'(op_i.n - i_q - NW'(1))
                       + 32'(op_i.ey) * 32'(i_q + NW'(1)));
          remx_d = '0; remy_d = '0; bit_d = '0;
          state_d = BkDiv;
        end
      end
      BkResp: begin
        if (!rv_q || rsp.ready) begin
          rv_d  = 1'b1;
          pop_o = 1'b1;
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  assign rsp.valid = rv_q;

  // occupancy memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_q <= mem[mem_ra];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkClear;
      clr_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; numx_q <= numx_d; numy_q <= numy_d;
    remx_q <= remx_d; remy_q <= remy_d;
    qx_q <= qx_d; qy_q <= qy_d; bit_q <= bit_d;
    free_q <= free_d;
    if (state_q == BkResp && state_d == BkIdle) rsp.data.path_free <= free_q;
  end

endmodule

// ===== hw/rtl/segment_collision_checker_unit.sv =====
// channel | dir | accepted when      | payload
// req     | in  | valid && ready     | req_t: type, cell, blocked, endpoints
// rsp     | out | valid && ready     | rsp_t: path_free
// cfg     | in  | valid && ready     | cfg_t: index, data (always ready)
//
// a write: the front accepts and pushes it, the back writes the cell
// a check: in the front square, 15 root steps, push; then in the back
// setup, per sample 22 divide steps, read, test over up to n+1 samples, then a response
// n up to 121
// reset: the back clears the 65536-cell grid, up to 3 requests wait
// the front keeps working while the back waits on a stalled response
module segment_collision_checker_unit import scc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  scc_req_if.sink   req,
  scc_rsp_if.source rsp,
  scc_cfg_if.sink   cfg
);

  logic [DimW-1:0] width_q, height_q, wlim, hlim;
  logic push, full, pop, empty;
  op_t  op_in, op_out;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(MaxDim);
      height_q <= DimW'(MaxDim);
    end else if (cfg.valid) begin
      if (cfg.data.index == CfgWidth) width_q <= cfg.data.data;
      if (cfg.data.index == CfgHeight) height_q <= cfg.data.data;
    end
  end

  assign wlim = (width_q > DimW'(MaxDim)) ? DimW'(MaxDim) : width_q;
  assign hlim = (height_q > DimW'(MaxDim)) ? DimW'(MaxDim) : height_q;

  scc_front u_front (
    .clk_i, .rst_ni, .req,
    .push_o(push), .op_o(op_in), .full_i(full)
  );

  scc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .op_i(op_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .op_o(op_out)
  );

  scc_back u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .op_i(op_out), .pop_o(pop),
    .wlim_i(wlim), .hlim_i(hlim), .rsp
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full)) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && empty)) else $error("pop from empty queue");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("response dropped under stall");

endmodule
